### rtl/sha1bs_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and round helpers for the SHA-1 byte stream hasher.
// No dependencies; every other file in rtl/ imports this package.
package sha1bs_pkg;

    localparam int unsigned QUEUE_DEPTH  = 4;
    localparam int unsigned DIGEST_WORDS = 5;
    localparam int unsigned BLOCK_BITS   = 512;

    localparam logic [6:0] ROUND_LAST  = 7'd79;
    localparam logic [5:0] POS_LAST    = 6'd63;
    localparam logic [5:0] POS_LEN     = 6'd56;
    localparam logic [2:0] IDX_LAST    = 3'd4;
    localparam logic [7:0] PAD_MARK    = 8'h80;

    localparam logic [31:0] IV0 = 32'h67452301;
    localparam logic [31:0] IV1 = 32'hEFCDAB89;
    localparam logic [31:0] IV2 = 32'h98BADCFE;
    localparam logic [31:0] IV3 = 32'h10325476;
    localparam logic [31:0] IV4 = 32'hC3D2E1F0;

    localparam logic [31:0] K0 = 32'h5A827999;
    localparam logic [31:0] K1 = 32'h6ED9EBA1;
    localparam logic [31:0] K2 = 32'h8F1BBCDC;
    localparam logic [31:0] K3 = 32'hCA62C1D6;

    // One queued request from the front end
    typedef struct packed {
        logic [7:0] data;
        logic       valid;
        logic       last;
    } req_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_FINAL,
        ST_PAD80,
        ST_PADZ,
        ST_PADLEN,
        ST_OUT
    } back_state_t;

    function automatic logic [31:0] rotl1(input logic [31:0] v);
        begin
            return {v[30:0], v[31]};
        end
    endfunction

    function automatic logic [31:0] round_f(input logic [6:0] r, input logic [31:0] b,
                                            input logic [31:0] c, input logic [31:0] d);
        begin
            if (r < 7'd20)
                return d ^ (b & (c ^ d));
            else if (r < 7'd40)
                return b ^ c ^ d;
            else if (r < 7'd60)
                return (b & c) | (d & (b | c));
            else
                return b ^ c ^ d;
        end
    endfunction

    function automatic logic [31:0] round_k(input logic [6:0] r);
        begin
            if (r < 7'd20)
                return K0;
            else if (r < 7'd40)
                return K1;
            else if (r < 7'd60)
                return K2;
            else
                return K3;
        end
    endfunction

endpackage

### rtl/sha1bs_front.sv
`timescale 1ns / 1ps
// Input side: accepts stream items, drops empty non-final ones, and queues the
// rest as requests for the hash engine. Depends on sha1bs_pkg.
module sha1bs_front #(
    parameter int unsigned DEPTH = sha1bs_pkg::QUEUE_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_tvalid,
    output logic              in_tready,
    input  logic [7:0]        in_data,
    input  logic              in_byte_valid,
    input  logic              in_last,
    output logic              req_valid,
    input  logic              req_ready,
    output sha1bs_pkg::req_t  req
);
    import sha1bs_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    req_t               q_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               push;
    logic               pop;

    assign in_tready = (count_reg != CNT_W'(DEPTH));
    // an empty item that does not end the message carries nothing
    assign push      = in_tvalid & in_tready & (in_byte_valid | in_last);
    assign req_valid = (count_reg != '0);
    assign pop       = req_valid & req_ready;
    assign req       = q_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= '{data: in_data, valid: in_byte_valid, last: in_last};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

### rtl/sha1bs_back.sv
`timescale 1ns / 1ps
// Hash engine: block assembly, padding, 80-round SHA-1 compression and
// digest word output. Depends on sha1bs_pkg.
module sha1bs_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  sha1bs_pkg::req_t  req,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [31:0]       out_word,
    output logic [2:0]        out_index,
    output logic              out_last
);
    import sha1bs_pkg::*;

    back_state_t            state_reg, state_next;
    logic [BLOCK_BITS-1:0]  blk_reg;
    logic [5:0]             pos_reg;
    logic [63:0]            msg_cnt_reg;
    logic [63:0]            len_reg;
    logic [31:0]            a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [31:0]            chain_reg [DIGEST_WORDS];
    logic [6:0]             round_reg;
    logic [2:0]             idx_reg;
    logic                   pad_reg;
    logic                   mark_reg;
    logic                   final_reg;

    logic                   feed;
    logic [7:0]             feed_byte;
    logic                   start;
    logic [63:0]            cnt_inc;
    logic [31:0]            w_new;
    logic [31:0]            t_sum;

    // blk_reg holds w[0] in its top word; w[i] = blk_reg[511-32i -: 32]
    assign w_new   = rotl1(blk_reg[511:480] ^ blk_reg[447:416] ^
                           blk_reg[255:224] ^ blk_reg[95:64]);
    assign t_sum   = {a_reg[26:0], a_reg[31:27]} + round_f(round_reg, b_reg, c_reg, d_reg)
                     + e_reg + round_k(round_reg) + blk_reg[511:480];
    assign cnt_inc = msg_cnt_reg + {63'd0, req.valid};
    assign start   = (state_next == ST_ROUND) && (state_reg != ST_ROUND);

    assign out_word  = chain_reg[idx_reg];
    assign out_index = idx_reg;
    assign out_last  = (idx_reg == IDX_LAST);

    always_comb
    begin
        state_next = state_reg;
        feed       = 1'b0;
        feed_byte  = '0;
        req_ready  = 1'b0;
        out_valid  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    feed      = req.valid;
                    feed_byte = req.data;
                    if (req.valid && pos_reg == POS_LAST)
                        state_next = ST_ROUND;
                    else if (req.last)
                        state_next = ST_PAD80;
                end
            end
            ST_ROUND:
            begin
                if (round_reg == ROUND_LAST)
                    state_next = ST_FINAL;
            end
            ST_FINAL:
            begin
                if (!pad_reg)
                    state_next = ST_IDLE;
                else if (final_reg)
                    state_next = ST_OUT;
                else if (!mark_reg)
                    state_next = ST_PAD80;
                else
                    state_next = ST_PADZ;
            end
            ST_PAD80:
            begin
                feed       = 1'b1;
                feed_byte  = PAD_MARK;
                state_next = (pos_reg == POS_LAST) ? ST_ROUND : ST_PADZ;
            end
            ST_PADZ:
            begin
                if (pos_reg == POS_LEN)
                    state_next = ST_PADLEN;
                else
                begin
                    feed = 1'b1;
                    if (pos_reg == POS_LAST)
                        state_next = ST_ROUND;
                end
            end
            ST_PADLEN:
            begin
                feed      = 1'b1;
                feed_byte = len_reg[63:56];
                if (pos_reg == POS_LAST)
                    state_next = ST_ROUND;
            end
            ST_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready && idx_reg == IDX_LAST)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // datapath payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (feed)
            blk_reg <= {blk_reg[BLOCK_BITS-9:0], feed_byte};
        else if (state_reg == ST_ROUND)
            blk_reg <= {blk_reg[BLOCK_BITS-33:0], w_new};

        if (start)
        begin
            a_reg <= chain_reg[0];
            b_reg <= chain_reg[1];
            c_reg <= chain_reg[2];
            d_reg <= chain_reg[3];
            e_reg <= chain_reg[4];
        end
        else if (state_reg == ST_ROUND)
        begin
            a_reg <= t_sum;
            b_reg <= a_reg;
            c_reg <= {b_reg[1:0], b_reg[31:2]};
            d_reg <= c_reg;
            e_reg <= d_reg;
        end

        if (state_reg == ST_IDLE && req_valid && req.last)
            len_reg <= {cnt_inc[60:0], 3'b000};
        else if (state_reg == ST_PADLEN)
            len_reg <= {len_reg[55:0], 8'h00};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            msg_cnt_reg  <= '0;
            round_reg    <= '0;
            idx_reg      <= '0;
            pad_reg      <= 1'b0;
            mark_reg     <= 1'b0;
            final_reg    <= 1'b0;
            chain_reg[0] <= IV0;
            chain_reg[1] <= IV1;
            chain_reg[2] <= IV2;
            chain_reg[3] <= IV3;
            chain_reg[4] <= IV4;
        end
        else
        begin
            if (feed)
                pos_reg <= pos_reg + 1'b1;

            if (state_reg == ST_IDLE && req_valid)
            begin
                msg_cnt_reg <= cnt_inc;
                if (req.last)
                    pad_reg <= 1'b1;
            end

            if (state_reg == ST_PAD80)
                mark_reg <= 1'b1;

            if (state_reg == ST_PADLEN && pos_reg == POS_LAST)
                final_reg <= 1'b1;

            if (start)
                round_reg <= '0;
            else if (state_reg == ST_ROUND)
                round_reg <= round_reg + 1'b1;

            if (state_reg == ST_FINAL)
            begin
                chain_reg[0] <= chain_reg[0] + a_reg;
                chain_reg[1] <= chain_reg[1] + b_reg;
                chain_reg[2] <= chain_reg[2] + c_reg;
                chain_reg[3] <= chain_reg[3] + d_reg;
                chain_reg[4] <= chain_reg[4] + e_reg;
            end

            if (state_reg == ST_OUT && out_ready)
            begin
                if (idx_reg == IDX_LAST)
                begin
                    // digest delivered: back to the initial state for the next message
                    idx_reg      <= '0;
                    pos_reg      <= '0;
                    msg_cnt_reg  <= '0;
                    pad_reg      <= 1'b0;
                    mark_reg     <= 1'b0;
                    final_reg    <= 1'b0;
                    chain_reg[0] <= IV0;
                    chain_reg[1] <= IV1;
                    chain_reg[2] <= IV2;
                    chain_reg[3] <= IV3;
                    chain_reg[4] <= IV4;
                end
                else
                begin
                    idx_reg <= idx_reg + 1'b1;
                end
            end
        end
    end

endmodule

### rtl/sha1_byte_stream_hasher_core.sv
`timescale 1ns / 1ps
// Top level of the SHA-1 byte stream hasher: request queue front end and hash engine.
// Depends on sha1bs_pkg, sha1bs_front and sha1bs_back.
//
// Takes one message byte per input request and returns the 160-bit SHA-1 digest as
// five 32-bit words (most significant first, tuser = word index, tlast on the fifth)
// after a request with tlast set; tuser = 0 with tlast marks an end without a byte,
// which allows the empty message. The engine takes bytes while it is idle, and every
// 64th byte starts the one-round-per-cycle compression unit (80 rounds, then the
// chaining add; the working registers load while the byte is taken), during which no
// bytes are taken. Ending a message feeds the padding bytes (0x80, zeros, then the
// 64-bit bit length) and one or two more compressions. A small request queue lets the
// input run ahead by up to QUEUE_DEPTH requests while a block compresses.
module sha1_byte_stream_hasher_core #(
    parameter int unsigned QUEUE_DEPTH = sha1bs_pkg::QUEUE_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] data_byte
    input  logic        s_tuser,    // [0] byte_valid
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // [31:0] digest_word
    output logic [2:0]  m_tuser,    // [2:0] word_index
    output logic        m_tlast
);
    import sha1bs_pkg::*;

    req_t req;
    logic req_valid;
    logic req_ready;

    sha1bs_front #(
        .DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_tvalid     (s_tvalid),
        .in_tready     (s_tready),
        .in_data       (s_tdata),
        .in_byte_valid (s_tuser),
        .in_last       (s_tlast),
        .req_valid     (req_valid),
        .req_ready     (req_ready),
        .req           (req)
    );

    sha1bs_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_word  (m_tdata),
        .out_index (m_tuser),
        .out_last  (m_tlast)
    );

endmodule
